// ----- hdl/tmps_pkg.sv -----
// Shared types and constants for the triangle maximum path sum block.
`default_nettype none

package tmps_pkg;

    // Largest triangle the row store can hold.
    localparam int MAX_ROWS    = 512;
    localparam int IDX_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CFG_W       = 10;
    localparam int CNT_W       = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
    localparam int WEIGHT_W    = 16;
    localparam int SUM_W       = 26;
    localparam int OUT_W       = 25;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // Where an entry sits in its row, which decides its parents.
    typedef enum logic [1:0] {
        POS_APEX,
        POS_LEFT,
        POS_MID,
        POS_RIGHT
    } pos_kind_t;

    // One classified weight on its way from the front to the back.
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [IDX_W-1:0]    col;
        pos_kind_t           kind;
        logic                final_row;
        logic                last;
    } entry_t;

endpackage

`default_nettype wire

// ----- hdl/tmps_front.sv -----
// Front end: row count register, position tracking and classification of each weight.
`default_nettype none

module tmps_front
    import tmps_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [CFG_W-1:0]    cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [WEIGHT_W-1:0] s_weight,
    input  wire logic                q_full,
    output logic                     q_push,
    output entry_t                   q_entry
);

    logic [CFG_W-1:0] row_count_reg;
    logic [IDX_W-1:0] row_idx_reg, row_idx_next;
    logic [IDX_W-1:0] col_idx_reg, col_idx_next;

    logic [CNT_W-1:0] rows_ext;
    logic [CNT_W-1:0] rows_eff;
    logic [IDX_W-1:0] last_row;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    logic             final_row;
    pos_kind_t        kind;

    always_comb begin
        rows_ext = CNT_W'(row_count_reg);
        if (rows_ext == CNT_W'(0)) begin
            rows_eff = CNT_W'(1);
        end else if (rows_ext > CNT_W'(MAX_ROWS)) begin
            rows_eff = CNT_W'(MAX_ROWS);
        end else begin
            rows_eff = rows_ext;
        end
        last_row  = IDX_W'(rows_eff - CNT_W'(1));
        r         = (row_idx_reg > last_row) ? last_row : row_idx_reg;
        c         = (col_idx_reg > r) ? r : col_idx_reg;
        final_row = (r == last_row);

        priority if (r == '0) begin
            kind = POS_APEX;
        end else if (c == '0) begin
            kind = POS_LEFT;
        end else if (c < r) begin
            kind = POS_MID;
        end else begin
            kind = POS_RIGHT;
        end

        if (c == r) begin
            col_idx_next = '0;
            row_idx_next = final_row ? '0 : IDX_W'(r + IDX_W'(1));
        end else begin
            col_idx_next = IDX_W'(c + IDX_W'(1));
            row_idx_next = r;
        end
    end

    assign s_ready             = !q_full;
    assign q_push              = s_valid && s_ready;
    assign q_entry.weight      = s_weight;
    assign q_entry.col         = c;
    assign q_entry.kind        = kind;
    assign q_entry.final_row   = final_row;
    assign q_entry.last        = final_row && (c == r);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= CFG_W'(1);
            row_idx_reg   <= '0;
            col_idx_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                row_count_reg <= cfg_wr_data;
            end
            if (q_push) begin
                row_idx_reg <= row_idx_next;
                col_idx_reg <= col_idx_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tmps_queue.sv -----
// Short queue of classified weights between the front and the back.
`default_nettype none

module tmps_queue
    import tmps_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t push_entry,
    output logic        full,
    input  wire logic   pop,
    output logic        head_valid,
    output entry_t      head_entry
);

    entry_t            slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + QPTR_W'(1));
            end
            if (pop) begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + QPTR_W'(1));
            end
            if (push && !pop) begin
                count_reg <= (QPTR_W+1)'(count_reg + (QPTR_W+1)'(1));
            end else if (pop && !push) begin
                count_reg <= (QPTR_W+1)'(count_reg - (QPTR_W+1)'(1));
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tmps_back.sv -----
// Back end: row store read-modify-write, add-max, running best and result register.
`default_nettype none

module tmps_back
    import tmps_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             head_valid,
    input  wire entry_t           head_entry,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [OUT_W-1:0]      m_best_sum
);

    logic [SUM_W-1:0] row_sums [MAX_ROWS];

    logic             b_valid_reg;
    entry_t           b_item_reg;
    logic [SUM_W-1:0] rd_data_reg;
    logic             byp_reg;
    logic [SUM_W-1:0] byp_data_reg;
    logic [SUM_W-1:0] left_parent_reg;
    logic [SUM_W-1:0] best_reg;
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_sum_reg;

    logic [SUM_W-1:0] old_sum;
    logic [SUM_W-1:0] parent_max;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] best_next;
    logic             out_free;
    logic             b_fire;
    logic             b_load;
    logic             bypass;

    always_comb begin
        // A weight that reads the entry the previous weight just wrote takes the new value.
        old_sum = byp_reg ? byp_data_reg : rd_data_reg;
        unique case (b_item_reg.kind)
            POS_APEX:  parent_max = '0;
            POS_LEFT:  parent_max = old_sum;
            POS_MID:   parent_max = (left_parent_reg > old_sum) ? left_parent_reg : old_sum;
            POS_RIGHT: parent_max = left_parent_reg;
            default:   parent_max = '0;
        endcase
        sum_wide = {1'b0, parent_max} + (SUM_W+1)'(b_item_reg.weight);
        sum      = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

        if (b_item_reg.col == '0 || sum > best_reg) begin
            best_next = sum;
        end else begin
            best_next = best_reg;
        end

        out_free = !m_valid_reg || m_ready;
        b_fire   = b_valid_reg && (!b_item_reg.last || out_free);
        b_load   = head_valid && (!b_valid_reg || b_fire);
        bypass   = b_fire && (b_item_reg.col == head_entry.col);
    end

    assign pop        = b_load;
    assign m_valid    = m_valid_reg;
    assign m_best_sum = m_sum_reg;

    // Row store: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (b_fire) begin
            row_sums[b_item_reg.col] <= sum;
        end
        if (b_load) begin
            rd_data_reg <= row_sums[head_entry.col];
        end
    end

    always_ff @(posedge aclk) begin
        if (b_load) begin
            b_item_reg   <= head_entry;
            byp_reg      <= bypass;
            byp_data_reg <= sum;
        end
        if (b_fire && b_item_reg.last) begin
            m_sum_reg <= (best_next > SUM_W'(OUT_MAX)) ? OUT_MAX : best_next[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg     <= 1'b0;
            left_parent_reg <= '0;
            best_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (b_load) begin
                b_valid_reg <= 1'b1;
            end else if (b_fire) begin
                b_valid_reg <= 1'b0;
            end

            if (b_fire) begin
                if (b_item_reg.last) begin
                    left_parent_reg <= '0;
                    best_reg        <= '0;
                end else begin
                    if (b_item_reg.kind == POS_LEFT || b_item_reg.kind == POS_MID) begin
                        left_parent_reg <= old_sum;
                    end
                    if (b_item_reg.final_row) begin
                        best_reg <= best_next;
                    end
                end
            end

            if (b_fire && b_item_reg.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/triangle_max_path_sum.sv -----
// Top level of the triangle maximum path sum block.
`default_nettype none

// This block takes the weights of a number triangle as beats on the s_ channel, row by row and
// left to right, with row r holding r+1 weights, and after the last weight of the final row it
// delivers one beat on the m_ channel carrying the largest top-to-bottom path sum. The number of
// rows comes from the row count register, written through cfg_wr_en and cfg_wr_data; the user
// must write it only while the block is idle, which the block itself does not enforce. Zero
// counts as one row and values above the store depth are clamped to it. The block sustains one
// weight per clock cycle unless the queue fills while a result waits to be taken. That figure
// is set by the row store in the back end, which does one read and one write per weight, with
// the value just written forwarded to the next weight when it reads the same entry. The front
// end classifies each weight by its position and places it in a four-entry queue, so the input
// keeps flowing while a finished result waits in the output register to be taken.

module triangle_max_path_sum
    import tmps_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [CFG_W-1:0]    cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [WEIGHT_W-1:0] s_weight,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [OUT_W-1:0]         m_best_sum
);

    // Classified beats travel from the front end through the queue to the back end.
    logic   q_full;
    logic   q_push;
    entry_t q_entry;
    logic   q_pop;
    logic   q_head_valid;
    entry_t q_head;

    // The front end owns the row count and the row and column position of the next weight.
    tmps_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_weight    (s_weight),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    // The queue lets the front end keep accepting while the back end waits on the output.
    tmps_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    // The back end updates the stored row in place and tracks the best sum of the final row.
    tmps_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_best_sum (m_best_sum)
    );

endmodule

`default_nettype wire
